// ===== hw/rtl/ufmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ufmt_pkg
// Shared constants and types for the unsigned decimal field formatter.
// ----------------------------------------------------------------------------
package ufmt_pkg;

  localparam int UFMT_MAX_FIELD = 64;   // default field limit
  localparam int VAL_W          = 64;   // input value width
  localparam int FLD_W          = 7;    // width/precision/length port width
  localparam int NDIG           = 20;   // decimal digits of a 64-bit value
  localparam int DIG_W          = 4;    // BCD digit width
  localparam int DIG_IDX_W      = 5;    // digit count width
  localparam int BITS_PER_CYC   = 4;    // double-dabble steps per cycle
  localparam int CONV_CYCLES    = VAL_W / BITS_PER_CYC;
  localparam int CONV_CNT_W     = $clog2(CONV_CYCLES);
  localparam int QDEPTH         = 2;    // front-to-back queue depth

  localparam logic [1:0] LEN_H  = 2'd1;
  localparam logic [1:0] LEN_HH = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_CALC,
    F_PUSH
  } fstate_t;

endpackage

// ===== hw/rtl/ufmt_front.sv =====
// ----------------------------------------------------------------------------
// ufmt_front
// Accepts a request, truncates the value, converts it to BCD by shift-add-3
// (four bits per cycle) and computes the field layout for the emitter.
// ----------------------------------------------------------------------------
module ufmt_front
  import ufmt_pkg::*;
#(
  parameter int MAX_FIELD = UFMT_MAX_FIELD,
  parameter int CW        = $clog2(UFMT_MAX_FIELD + 1),
  parameter int ENTRY_W   = NDIG * DIG_W + DIG_IDX_W + 2 * CW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VAL_W-1:0]   value,
  input  logic [1:0]         length_mod,
  input  logic               upper_type,
  input  logic [FLD_W-1:0]   width,
  input  logic [FLD_W-1:0]   precision,
  input  logic               precision_given,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int BCD_W = NDIG * DIG_W;
  localparam logic [FLD_W-1:0] MAXF = FLD_W'(MAX_FIELD);
  localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(CONV_CYCLES - 1);

  fstate_t               state_r, state_nxt;
  logic [VAL_W-1:0]      bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CONV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]         wid_r, wid_nxt;
  logic [CW-1:0]         prec_r, prec_nxt;
  logic                  given_r, given_nxt;
  logic [ENTRY_W-1:0]    data_r, data_nxt;

  logic [VAL_W-1:0]      trunc_val;
  logic [DIG_IDX_W-1:0]  ndig_c;
  logic [CW-1:0]         mindig_c, body_c, total_c;
  logic                  accept;

  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIG_W +: DIG_W] >= 4'd5) begin
        adj[i*DIG_W +: DIG_W] = bcd[i*DIG_W +: DIG_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  always_comb begin
    if (length_mod == LEN_HH && !upper_type) begin
      trunc_val = {{(VAL_W-8){1'b0}}, value[7:0]};
    end else if (length_mod == LEN_H || length_mod == LEN_HH) begin
      trunc_val = {{(VAL_W-16){1'b0}}, value[15:0]};
    end else begin
      trunc_val = value;
    end
  end

  always_comb begin
    ndig_c = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] != '0) begin
        ndig_c = DIG_IDX_W'(i + 1);
      end
    end
    if (ndig_c == '0 && !(given_r && prec_r == '0)) begin
      ndig_c = DIG_IDX_W'(1);
    end
    mindig_c = given_r ? prec_r : CW'(1);
    body_c   = (mindig_c > CW'(ndig_c)) ? mindig_c : CW'(ndig_c);
    total_c  = (wid_r > body_c) ? wid_r : body_c;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        if (cnt_r == CONV_LAST) begin
          state_nxt = F_CALC;
        end
      end
      F_CALC: begin
        state_nxt = (total_c == '0) ? F_IDLE : F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE:  in_ready   = 1'b1;
      F_PUSH:  push_valid = 1'b1;
      default: begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
      end
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign push_data = data_r;

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    wid_nxt   = wid_r;
    prec_nxt  = prec_r;
    given_nxt = given_r;
    data_nxt  = data_r;
    if (accept) begin
      bin_nxt   = trunc_val;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      wid_nxt   = (width > MAXF) ? CW'(MAX_FIELD) : width[CW-1:0];
      prec_nxt  = (precision > MAXF) ? CW'(MAX_FIELD) : precision[CW-1:0];
      given_nxt = precision_given;
    end else if (state_r == F_CONV) begin
      bcd_nxt = bcd_r;
      for (int k = 0; k < BITS_PER_CYC; k++) begin
        bcd_nxt = dd_step(bcd_nxt, bin_r[VAL_W-1-k]);
      end
      bin_nxt = bin_r << BITS_PER_CYC;
      cnt_nxt = cnt_r + 1'b1;
    end else if (state_r == F_CALC) begin
      data_nxt = {total_c, body_c, ndig_c, bcd_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    wid_r   <= wid_nxt;
    prec_r  <= prec_nxt;
    given_r <= given_nxt;
    data_r  <= data_nxt;
  end

`ifndef ASSERT_OFF
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_CONV && cnt_r == CONV_LAST) |=> state_r == F_CALC)
    else $error("conversion did not finish after the last step");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> data_r[ENTRY_W-1 -: CW] != '0)
    else $error("empty field pushed to the emitter");
`endif

endmodule

// ===== hw/rtl/ufmt_queue.sv =====
// ----------------------------------------------------------------------------
// ufmt_queue
// Short register queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
module ufmt_queue
  import ufmt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QDEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1 && count_r <= CNT_FULL)
    else $error("queue occupancy out of step with transactions");
`endif

endmodule

// ===== hw/rtl/ufmt_back.sv =====
// ----------------------------------------------------------------------------
// ufmt_back
// Character emitter: walks a field from the left, one character per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ufmt_back
  import ufmt_pkg::*;
#(
  parameter int CW        = $clog2(UFMT_MAX_FIELD + 1),
  parameter int ENTRY_W   = NDIG * DIG_W + DIG_IDX_W + 2 * CW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last,
  output logic [FLD_W-1:0]   out_len
);

  localparam int BCD_W = NDIG * DIG_W;

  logic                 busy_r, busy_nxt;
  logic [BCD_W-1:0]     digits_r, digits_nxt;
  logic [DIG_IDX_W-1:0] ndig_r, ndig_nxt;
  logic [CW-1:0]        body_r, body_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [FLD_W-1:0]     out_len_r, out_len_nxt;

  logic [BCD_W-1:0]     in_digits;
  logic [DIG_IDX_W-1:0] in_ndig;
  logic [CW-1:0]        in_body, in_total;
  logic                 adv, pop;
  logic [DIG_W-1:0]     dsel;
  logic [7:0]           ch;

  assign {in_total, in_body, in_ndig, in_digits} = pop_data;

  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign pop       = pop_valid && (!busy_r || (adv && rem_r == '0));
  assign pop_ready = !busy_r || (adv && rem_r == '0);

  always_comb begin
    dsel = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (rem_r == CW'(i)) begin
        dsel = digits_r[i*DIG_W +: DIG_W];
      end
    end
    if (rem_r < CW'(ndig_r)) begin
      ch = CH_ZERO + {4'd0, dsel};
    end else if (rem_r < body_r) begin
      ch = CH_ZERO;
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    digits_nxt    = digits_r;
    ndig_nxt      = ndig_r;
    body_nxt      = body_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = (rem_r == '0);
      out_len_nxt   = FLD_W'(total_r);
      rem_nxt       = rem_r - 1'b1;
      if (rem_r == '0) begin
        busy_nxt = 1'b0;
      end
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt   = 1'b1;
      digits_nxt = in_digits;
      ndig_nxt   = in_ndig;
      body_nxt   = in_body;
      total_nxt  = in_total;
      rem_nxt    = in_total - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    ndig_r     <= ndig_nxt;
    body_r     <= body_nxt;
    total_r    <= total_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_len   = out_len_r;

`ifndef ASSERT_OFF
  a_rem_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < total_r)
    else $error("emit position beyond field length");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && (out_last_r == ($past(rem_r) == '0)))
    else $error("last flag does not match final character");
`endif

endmodule

// ===== hw/rtl/unsigned_decimal_field_formatter_unit.sv =====
// Path: a request is converted, laid out and pushed, then queued and emitted through
//   a registered output stage. Throughput: one character per cycle while out_tready
//   is high; the shift-add-3 converter takes a new request once it has finished the
//   last one, overlapping the emitter through a 2-entry queue.
// Reset: synchronous, active low; clears control state only, no clearing pass.
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter_unit
// Formats an unsigned value as a padded decimal field, one character per
// output transaction.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter_unit
  import ufmt_pkg::*;
#(
  parameter int MAX_FIELD = UFMT_MAX_FIELD
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[63:0], width[70:64], precision[77:71], precision_given[78], zero[79]
  input  logic [79:0] in_tdata,
  // length_mod[1:0], upper_type[2]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_char[7:0], field_length[14:8], zero[15]
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  localparam int CW      = $clog2(MAX_FIELD + 1);
  localparam int ENTRY_W = NDIG * DIG_W + DIG_IDX_W + 2 * CW;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;
  logic [7:0]         out_char;
  logic [FLD_W-1:0]   out_len;

  ufmt_front #(
    .MAX_FIELD (MAX_FIELD),
    .CW        (CW),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .value           (in_tdata[63:0]),
    .length_mod      (in_tuser[1:0]),
    .upper_type      (in_tuser[2]),
    .width           (in_tdata[70:64]),
    .precision       (in_tdata[77:71]),
    .precision_given (in_tdata[78]),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  ufmt_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ufmt_back #(
    .CW        (CW),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .out_len   (out_len)
  );

  assign out_tdata = {1'b0, out_len, out_char};

endmodule
